FILE: sv/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority queue check failed");

// Next-cycle implication, disabled while reset is held.
`define MPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority queue check failed");

`endif

FILE: sv/mpq_pkg.sv
// Types, codes and ordering function for the sorted priority queue.
`default_nettype none

package mpq_pkg;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [31:0] freq;
        logic [31:0] key;
        logic [15:0] node;
    } entry_t;

    // Broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic extract;
    } cell_ctl_t;

    // True if a strictly leaves before b (lower freq, then larger key).
    function automatic logic leaves_before(input entry_t a, input entry_t b);
        leaves_before = (a.freq < b.freq) || ((a.freq == b.freq) && (a.key > b.key));
    endfunction

endpackage

`default_nettype wire

FILE: sv/min_priority_queue_freq_key.sv
// Top level of the sorted minimum priority queue built from a chain of cells.
`default_nettype none

// Bounded minimum priority queue for Huffman tree building. Entries sit in
// a chain of QUEUE_DEPTH cells kept sorted at all times: cell 0 holds the
// minimum (lowest freq, then largest key, then oldest). An insert request
// is compared against every cell at once and the chain opens a gap at the
// right spot by shifting the tail one cell right; an extract takes cell 0
// and shifts the whole chain one cell left. Each request therefore updates
// the whole cell chain, and its result (status, removed entry,
// count, peek at the new minimum) appears in the output register on the
// next cycle. A new request is taken every cycle as long as the output
// register is empty or being drained in that same cycle. Extract on empty
// reports ST_EMPTY, insert on full is dropped and reports ST_FULL; neither
// changes the contents. No clearing pass is needed after reset.

`include "assert_macros.svh"

module min_priority_queue_freq_key
    import mpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic        req_type,
    input  wire logic [31:0] freq,
    input  wire logic [31:0] tie_key,
    input  wire logic [15:0] node_handle,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [1:0]  status,
    output      logic [15:0] out_node,
    output      logic [31:0] out_freq,
    output      logic [31:0] out_key,
    output      logic [4:0]  count,
    output      logic        peek_valid,
    output      logic [15:0] peek_node,
    output      logic [31:0] peek_freq,
    output      logic [31:0] peek_key
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // fill level
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg,  status_next;
    entry_t      removed_reg, removed_next;
    entry_t      peek_reg,    peek_next;
    logic        peek_valid_reg, peek_valid_next;
    logic [CNT_W-1:0] out_count_reg;

    // request decode
    logic      accept;
    logic      is_full;
    logic      is_empty;
    cell_ctl_t ctl;
    entry_t    new_entry;

    // chain wiring
    entry_t cell_entry [QUEUE_DEPTH];
    entry_t cell_next  [QUEUE_DEPTH];
    logic   cell_before [QUEUE_DEPTH];

    logic [31:0] count_wide;

    // Result register frees up when it is empty or drained this cycle.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (count_reg == '0);

    assign new_entry = '{freq: freq, key: tie_key, node: node_handle};

    assign ctl.insert  = accept && (req_type == REQ_INSERT)  && !is_full;
    assign ctl.extract = accept && (req_type == REQ_EXTRACT) && !is_empty;

    // Sorted chain: cell 0 is the head (current minimum).
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_e;
            logic   left_b;
            entry_t right_e;

            if (gi == 0)
            begin : g_head
                assign left_e = new_entry;
                assign left_b = 1'b0;
            end
            else
            begin : g_body
                assign left_e = cell_entry[gi-1];
                assign left_b = cell_before[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[gi+1];
            end

            mpq_cell u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .occupied    (CNT_W'(gi) < count_reg),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .left_before (left_b),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .new_ahead   (cell_before[gi]),
                .entry_next  (cell_next[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        status_next  = ST_OK;
        removed_next = '0;
        priority if (accept && (req_type == REQ_INSERT))
        begin
            if (is_full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (accept)
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                count_next   = count_reg - CNT_W'(1);
                removed_next = cell_entry[0];
            end
        end
        else
        begin
            count_next = count_reg;
        end
        // peek at the head as it will stand after this request
        peek_valid_next = (count_next != '0);
        peek_next       = peek_valid_next ? cell_next[0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            peek_reg       <= peek_next;
            peek_valid_reg <= peek_valid_next;
            out_count_reg  <= count_next;
        end
    end

    assign count_wide = 32'(out_count_reg);

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign out_node   = removed_reg.node;
    assign out_freq   = removed_reg.freq;
    assign out_key    = removed_reg.key;
    assign count      = count_wide[4:0];
    assign peek_valid = peek_valid_reg;
    assign peek_node  = peek_reg.node;
    assign peek_freq  = peek_reg.freq;
    assign peek_key   = peek_reg.key;

    // Fill level never passes the chain length.
    `MPQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))

    // A successful insert grows the fill level by exactly one.
    `MPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.insert,
        count_reg == $past(count_reg) + CNT_W'(1))

    // An empty report always comes with an empty queue and no peek.
    `MPQ_ASSERT_NOW(a_empty_result, clk, rst_n, out_valid_reg && (status_reg == ST_EMPTY),
        (out_count_reg == '0) && !peek_valid_reg)

    // An extract hands out what sat at the head of the chain.
    `MPQ_ASSERT_NEXT(a_extract_head, clk, rst_n, ctl.extract,
        (removed_reg == $past(cell_entry[0])) && (status_reg == ST_OK))

endmodule

`default_nettype wire

FILE: sv/mpq_cell.sv
// One slot of the sorted queue: holds an entry, shifts toward either neighbor.
`default_nettype none

module mpq_cell
    import mpq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire logic      occupied,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_before,
    input  wire entry_t    right_entry,
    output      entry_t    entry,
    output      logic      new_ahead,
    output      entry_t    entry_next
);

    entry_t entry_reg;

    // new item belongs at or left of this slot (ties stay behind older ones)
    assign new_ahead = !occupied || leaves_before(new_entry, entry_reg);

    always_comb
    begin
        entry_next = entry_reg;
        priority if (ctl.insert)
        begin
            if (new_ahead)
            begin
                entry_next = left_before ? left_entry : new_entry;
            end
        end
        else if (ctl.extract)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

FILE: test/min_priority_queue_freq_key_tb.sv
// Self-checking testbench for the sorted minimum priority queue.
module min_priority_queue_freq_key_tb;
    import mpq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1400;
    // Window of requests/results in which neither side ever idles.
    localparam int QUIET_FROM   = 500;
    localparam int QUIET_TO     = 800;
    // Second point where the sender waits for the queue to drain.
    localparam int MID_SYNC     = 1000;
    localparam int IDLE_PCT     = 16;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic        op;
        logic [31:0] freq;
        logic [31:0] key;
        logic [15:0] node;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rm_node;
        logic [31:0] rm_freq;
        logic [31:0] rm_key;
        logic [4:0]  count;
        logic        peek_valid;
        logic [15:0] peek_node;
        logic [31:0] peek_freq;
        logic [31:0] peek_key;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [31:0] freq;
    logic [31:0] tie_key;
    logic [15:0] node_handle;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] out_node;
    logic [31:0] out_freq;
    logic [31:0] out_key;
    logic [4:0]  count;
    logic        peek_valid;
    logic [15:0] peek_node;
    logic [31:0] peek_freq;
    logic [31:0] peek_key;

    // Requests waiting to be driven, and outcomes waiting to come back.
    request_t req_backlog[$];
    outcome_t pending_outcomes[$];

    // Our own copy of the queue contents, kept in arrival order.
    entry_t   held[$];

    logic     req_taken;      // request accepted at the last rising edge
    int       sent_count;
    int       outcomes_seen;
    int       directed_len;
    int       cycles;
    int       fail_count;
    int       n_insert;
    int       n_extract;
    int       n_full;
    int       n_empty;
    int       deepest;

    min_priority_queue_freq_key #(
        .QUEUE_DEPTH (DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .freq        (freq),
        .tie_key     (tie_key),
        .node_handle (node_handle),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .out_node    (out_node),
        .out_freq    (out_freq),
        .out_key     (out_key),
        .count       (count),
        .peek_valid  (peek_valid),
        .peek_node   (peek_node),
        .peek_freq   (peek_freq),
        .peek_key    (peek_key)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Slot of the entry that leaves next: lowest freq, then largest key.
    // Scanning oldest to newest and replacing only on a strict win keeps
    // the oldest of fully equal entries.
    function automatic int min_slot();
        int best = 0;
        for (int i = 1; i < held.size(); i++)
        begin
            if (held[i].freq < held[best].freq ||
                (held[i].freq == held[best].freq && held[i].key > held[best].key))
                best = i;
        end
        return best;
    endfunction

    // Apply one request to the local queue copy and return what the block
    // should report for it.
    function automatic outcome_t queue_outcome(request_t r);
        outcome_t o;
        entry_t   e;
        int       m;
        o = '0;
        o.status = ST_OK;
        if (r.op == REQ_INSERT)
        begin
            n_insert++;
            if (held.size() >= DEPTH)
            begin
                // full: entry dropped, contents untouched
                o.status = ST_FULL;
                n_full++;
            end
            else
            begin
                e.freq = r.freq;
                e.key  = r.key;
                e.node = r.node;
                held.insert(held.size(), e);
            end
        end
        else
        begin
            n_extract++;
            if (held.size() == 0)
            begin
                o.status = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                m = min_slot();
                o.rm_node = held[m].node;
                o.rm_freq = held[m].freq;
                o.rm_key  = held[m].key;
                held.delete(m);
            end
        end
        o.count = 5'(held.size());
        if (held.size() > deepest)
            deepest = held.size();
        // peek fields stay zero when the queue ends up empty
        if (held.size() != 0)
        begin
            m = min_slot();
            o.peek_valid = 1'b1;
            o.peek_node  = held[m].node;
            o.peek_freq  = held[m].freq;
            o.peek_key   = held[m].key;
        end
        return o;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    function automatic void add_req(logic op, logic [31:0] f, logic [31:0] k,
                                    logic [15:0] h);
        request_t r;
        r.op   = op;
        r.freq = f;
        r.key  = k;
        r.node = h;
        req_backlog.insert(req_backlog.size(), r);
    endfunction

    // Mostly tiny values so that freq and key ties are common, with
    // full-range and near-limit values mixed in.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 32'($urandom_range(0, 3));
            5, 6:          return $urandom;
            7:             return 32'hFFFF_FFFC + 32'($urandom_range(0, 3));
            default:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
        endcase
    endfunction

    // Driver: launches requests at the falling edge. A new request only goes
    // out once the previous one was accepted, so valid and payload hold.
    always @(negedge clk)
    begin : drive
        request_t nxt;
        logic     quiet;
        logic     drain_hold;
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                quiet = (sent_count >= QUIET_FROM && sent_count < QUIET_TO);
                // at the sync points hold off until every outcome is back
                drain_hold = (sent_count == directed_len || sent_count == MID_SYNC) &&
                             pending_outcomes.size() != 0;
                if (req_backlog.size() != 0 && !drain_hold &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    nxt = req_backlog.pop_front();
                    in_valid    <= 1'b1;
                    req_type    <= nxt.op;
                    freq        <= nxt.freq;
                    tie_key     <= nxt.key;
                    node_handle <= nxt.node;
                    sent_count++;
                end
                else
                    in_valid <= 1'b0;
            end
            quiet = (outcomes_seen >= QUIET_FROM && outcomes_seen < QUIET_TO);
            out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: checks each accepted result against the oldest outcome, then
    // records the request accepted at this edge. The output is registered,
    // so a result never belongs to the request taken at the same edge.
    always @(posedge clk)
    begin : watch
        outcome_t want;
        outcome_t fresh;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d outcomes outstanding",
                     cycles, pending_outcomes.size());
            $display("FAIL");
            $finish;
        end
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            outcomes_seen++;
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with no request outstanding: status %h node %h",
                         $time, status, out_node);
                fail_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("status",     want.status,     status);
                check_field("out_node",   want.rm_node,    out_node);
                check_field("out_freq",   want.rm_freq,    out_freq);
                check_field("out_key",    want.rm_key,     out_key);
                check_field("count",      want.count,      count);
                check_field("peek_valid", want.peek_valid, peek_valid);
                check_field("peek_node",  want.peek_node,  peek_node);
                check_field("peek_freq",  want.peek_freq,  peek_freq);
                check_field("peek_key",   want.peek_key,   peek_key);
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            fresh = queue_outcome({req_type, freq, tie_key, node_handle});
            pending_outcomes.insert(pending_outcomes.size(), fresh);
        end
    end

    initial
    begin : stimulus
        int n;
        int ext_pct;
        int episode;
        in_valid      = 1'b0;
        req_type      = REQ_INSERT;
        freq          = '0;
        tie_key       = '0;
        node_handle   = '0;
        out_ready     = 1'b0;
        req_taken     = 1'b0;
        sent_count    = 0;
        outcomes_seen = 0;
        cycles        = 0;
        fail_count    = 0;
        n_insert      = 0;
        n_extract     = 0;
        n_full        = 0;
        n_empty       = 0;
        deepest       = 0;
        directed_len  = -1;
        rst_n         = 1'b0;

        // Directed: extract on empty, field extremes, freq/key ties and
        // fully equal entries that must leave oldest first.
        add_req(REQ_EXTRACT, 32'h0, 32'h0, 16'h0);
        add_req(REQ_INSERT,  32'h0, 32'h0, 16'h0);
        add_req(REQ_INSERT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        add_req(REQ_INSERT,  32'd5, 32'd7, 16'd1);
        add_req(REQ_INSERT,  32'd5, 32'd9, 16'd2);
        add_req(REQ_INSERT,  32'd5, 32'd9, 16'd3);
        add_req(REQ_INSERT,  32'd5, 32'd9, 16'd4);
        add_req(REQ_INSERT,  32'hFFFF_FFFF, 32'h0, 16'h8000);
        add_req(REQ_INSERT,  32'h0, 32'hFFFF_FFFF, 16'h7FFF);
        repeat (8)
            add_req(REQ_EXTRACT, $urandom, $urandom, 16'($urandom));
        add_req(REQ_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        directed_len = req_backlog.size();

        // Random: episodes that lean toward filling, draining or a mix, so
        // the queue keeps hitting both full and empty. The first episode
        // overfills on purpose; a few percent of requests are pure noise.
        episode = 0;
        while (req_backlog.size() < directed_len + RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       ext_pct = 12;
                1:       ext_pct = 85;
                default: ext_pct = 50;
            endcase
            n = $urandom_range(1, 24);
            if (episode == 0)
            begin
                ext_pct = 0;
                n = DEPTH + 3;
            end
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 5)
                    add_req(1'($urandom), $urandom, $urandom, 16'($urandom));
                else
                    add_req(($urandom_range(0, 99) < ext_pct) ? REQ_EXTRACT : REQ_INSERT,
                            pick_word(), pick_word(),
                            $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom));
            end
            episode++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_backlog.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d requests: %0d inserts (%0d dropped on full), %0d extracts (%0d on empty)",
                 sent_count, n_insert, n_full, n_extract, n_empty);
        $display("deepest fill %0d of %0d, %0d results checked, %0d mismatches",
                 deepest, DEPTH, outcomes_seen, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/mpq_pkg.sv
sv/mpq_cell.sv
sv/min_priority_queue_freq_key.sv
test/min_priority_queue_freq_key_tb.sv
